// File: sv/betd_pkg.sv
// package: constants, types and helpers for the block energy tone detector
`default_nettype none
package betd_pkg;
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int MAX_BLOCK_LEN_DEF = 4096;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;
  localparam int LEN_W   = 13;
  localparam int RUN_W   = 16;
  localparam int SUM_W   = 48;
  localparam int SM_W    = 32;
  localparam logic [16:0] COEF_KEEP = 17'd45875;
  localparam logic [16:0] COEF_NEW  = 17'd19661;
  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  localparam logic [IDX_W-1:0] REG_BLOCK_LEN = 3'd0;
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [IDX_W-1:0] REG_RATIO     = 3'd2;
  localparam logic [IDX_W-1:0] REG_HIT       = 3'd3;
  localparam logic [IDX_W-1:0] REG_MISS      = 3'd4;
  localparam logic [IDX_W-1:0] REG_RCHECK    = 3'd5;
  localparam logic [IDX_W-1:0] REG_WEAK      = 3'd6;

  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [15:0] sample;
    logic [15:0] filtered;
    logic       batch_end;
  } in_item_t;

  typedef struct packed {
    logic detected;
    logic block_done;
    logic batch_answer;
  } out_item_t;
endpackage
`default_nettype wire

// File: sv/betd_if.sv
// valid/ready channel interface
`default_nettype none
interface betd_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/block_energy_tone_detector_top.sv
// top level of the block energy tone detector
`default_nettype none
// Tone detector on block energies. Each input transfer carries a raw sample and
// its band-filtered value (both signed Q1.15); the squares are summed over
// block_len samples (0 acts as 1, values above MAX_BLOCK_LEN are clamped). A
// sample that does not close a block is answered through S_ACC and S_OUT. A
// block-closing sample runs two bit-serial divides on one shared divider
// and then steps one shared 48-bit multiply-add and compare unit through the
// smoother updates and the ratio tests. One item at a time; the input is not
// ready while an item is at work or its result waits. cmd=1 clears all
// running state and answers all zeros. No clearing pass.
module block_energy_tone_detector_top #(
  parameter int MAX_BLOCK_LEN = betd_pkg::MAX_BLOCK_LEN_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  betd_if.sink                               in_ch,
  betd_if.source                             out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [betd_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [betd_pkg::CFG_W-1:0]    cfg_data
);
  import betd_pkg::*;

  // sample width is fixed by the transfer format
  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
  localparam int SQ_W = 2 * SAMPLE_BITS;

  // configuration registers
  logic [LEN_W-1:0] block_len;
  logic [31:0]      energy_threshold;
  logic [15:0]      energy_ratio;
  logic [RUN_W-1:0] hit_blocks, miss_blocks;
  logic             ratio_check, weak_arm_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_len <= LEN_W'(160); energy_threshold <= '0; energy_ratio <= 16'd256;
      hit_blocks <= 16'd1; miss_blocks <= 16'd1; ratio_check <= 1'b0;
      weak_arm_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_LEN: block_len        <= cfg_data[LEN_W-1:0];
        REG_THRESHOLD: energy_threshold <= cfg_data[31:0];
        REG_RATIO:     energy_ratio     <= cfg_data[15:0];
        REG_HIT:       hit_blocks       <= cfg_data[15:0];
        REG_MISS:      miss_blocks      <= cfg_data[15:0];
        REG_RCHECK:    ratio_check      <= cfg_data[0];
        REG_WEAK:      weak_arm_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective block length, clamped
  logic [16:0] len_eff;
  always_comb begin
    if (block_len == '0) len_eff = 17'd1;
    else if (17'(block_len) > 17'(MAX_BLOCK_LEN)) len_eff = 17'(MAX_BLOCK_LEN);
    else len_eff = 17'(block_len);
  end

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_ACC   = 10'b0000000010,
    S_DIVI  = 10'b0000000100,
    S_DIVO  = 10'b0000001000,
    S_SMI   = 10'b0000010000,
    S_SMO   = 10'b0000100000,
    S_CMP1  = 10'b0001000000,
    S_CMP2  = 10'b0010000000,
    S_SCORE = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;
  state_t state;

  // running state
  logic [SUM_W-1:0] input_energy_sum, output_energy_sum;
  logic [SM_W-1:0]  input_smoother, output_smoother;
  logic [16:0]      samples_in_block;
  logic [RUN_W-1:0] hit_run, miss_run;
  logic             tone_present;

  in_item_t  item;
  out_item_t res;
  logic [SUM_W-1:0] mean_in, mean_out;
  logic [1:0]       sub;          // multiply-add sub-step
  logic [SUM_W+1:0] acc;          // shared unit accumulator
  logic             strong_ok, weak_ok;

  // squares of the two samples
  function automatic logic [SQ_W-1:0] sq(input logic [15:0] raw);
    logic [SAMPLE_BITS-1:0] v;
    logic [SAMPLE_BITS-1:0] mag;
    begin
      v   = raw[SAMPLE_BITS-1:0];
      mag = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
      // most negative value: its magnitude is 2^(n-1), exact in n bits unsigned
      sq  = SQ_W'(mag) * SQ_W'(mag);
    end
  endfunction

  // shared divider
  logic             div_start, div_busy;
  logic [SUM_W-1:0] div_num, div_quo;
  betd_div #(.NUM_W(SUM_W), .DEN_W(17)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num),
    .den(samples_in_block), .busy(div_busy), .quo(div_quo)
  );

  // shared multiply-add operand selection: one 17 x 48 product per cycle
  logic [16:0]      mul_a;
  logic [SUM_W-1:0] mul_b;
  logic [SUM_W+16:0] prod;
  always_comb begin
    mul_a = '0; mul_b = '0;
    case (state)
      S_SMI: begin
        mul_a = (sub == 2'd0) ? COEF_KEEP : COEF_NEW;
        mul_b = (sub == 2'd0) ? SUM_W'(input_smoother) : mean_in;
      end
      S_SMO: begin
        mul_a = (sub == 2'd0) ? COEF_KEEP : COEF_NEW;
        mul_b = (sub == 2'd0) ? SUM_W'(output_smoother) : mean_out;
      end
      S_CMP1: begin
        mul_a = (sub == 2'd0) ? 17'd256 : {1'b0, energy_ratio};
        mul_b = SUM_W'((sub == 2'd0) ? output_smoother : input_smoother);
      end
      S_CMP2: begin
        mul_a = (sub == 2'd0) ? 17'd20 : 17'd17;
        mul_b = SUM_W'((sub == 2'd0) ? output_smoother : input_smoother);
      end
      default: ;
    endcase
    prod = (SUM_W+17)'(mul_a) * (SUM_W+17)'(mul_b);
  end

  logic hit_now;
  logic [RUN_W-1:0] hit_inc, miss_inc;
  assign hit_inc  = (hit_run  == RUN_MAX) ? hit_run  : hit_run  + 1'b1;
  assign miss_inc = (miss_run == RUN_MAX) ? miss_run : miss_run + 1'b1;

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data  = res;
  assign div_start = ((state == S_DIVI) || (state == S_DIVO)) && (sub == 2'd0);
  assign div_num   = (state == S_DIVI) ? input_energy_sum : output_energy_sum;
  assign hit_now = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      input_energy_sum <= '0; output_energy_sum <= '0;
      input_smoother <= '0; output_smoother <= '0;
      samples_in_block <= '0; hit_run <= '0; miss_run <= '0;
      tone_present <= 1'b0; sub <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_ch.valid) begin
          item  <= in_ch.data;
          state <= S_ACC;
        end
        S_ACC: begin
          if (item.cmd == CMD_CLEAR) begin
            input_energy_sum <= '0; output_energy_sum <= '0;
            input_smoother <= '0; output_smoother <= '0;
            samples_in_block <= '0; hit_run <= '0; miss_run <= '0;
            tone_present <= 1'b0;
            res   <= '0;
            state <= S_OUT;
          end else begin
            input_energy_sum  <= input_energy_sum  + SUM_W'(sq(item.sample));
            output_energy_sum <= output_energy_sum + SUM_W'(sq(item.filtered));
            samples_in_block  <= samples_in_block + 1'b1;
            if (samples_in_block + 1'b1 >= len_eff) begin
              sub   <= 2'd0;
              state <= S_DIVI;
            end else begin
              res   <= '{detected: tone_present, block_done: 1'b0,
                         batch_answer: item.batch_end};
              state <= S_OUT;
            end
          end
        end
        S_DIVI, S_DIVO: begin
          if (sub == 2'd0) sub <= 2'd1;
          else if (!div_busy) begin
            sub <= 2'd0;
            if (state == S_DIVI) begin
              mean_in <= div_quo; state <= S_DIVO;
            end else begin
              mean_out <= div_quo; acc <= '0; state <= S_SMI;
            end
          end
        end
        S_SMI, S_SMO: begin
          // acc = keep*s + new*mean, then round and shift
          if (sub == 2'd0) begin
            acc <= prod[SUM_W+1:0] + (SUM_W+2)'(32768); sub <= 2'd1;
          end else begin
            if (state == S_SMI) begin
              input_smoother <= SM_W'((acc + prod[SUM_W+1:0]) >> 16);
              state <= S_SMO;
            end else begin
              output_smoother <= SM_W'((acc + prod[SUM_W+1:0]) >> 16);
              state <= S_CMP1;
            end
            sub <= 2'd0;
          end
        end
        S_CMP1, S_CMP2: begin
          if (sub == 2'd0) begin
            acc <= prod[SUM_W+1:0]; sub <= 2'd1;
          end else begin
            if (state == S_CMP1) begin
              strong_ok <= acc > prod[SUM_W+1:0]; state <= S_CMP2;
            end else begin
              weak_ok <= acc > prod[SUM_W+1:0]; state <= S_SCORE;
            end
            sub <= 2'd0;
          end
        end
        S_SCORE: begin
          logic tp;
          logic [RUN_W-1:0] hr, mr;
          tp = tone_present; hr = hit_run; mr = miss_run;
          if (mean_out >= SUM_W'(energy_threshold)) begin
            if (!ratio_check || strong_ok) begin
              hr = hit_inc; mr = '0;
            end else begin
              mr = miss_inc;
              if (mr >= miss_blocks) begin hr = '0; tp = 1'b0; end
            end
            if (hr >= hit_blocks) tp = 1'b1;
          end else if (weak_arm_enable && ratio_check &&
                       {mean_out, 1'b0} >= (SUM_W+1)'(energy_threshold) && weak_ok) begin
            hr = hit_inc; mr = '0;
            if (hr >= hit_blocks) tp = 1'b1;
          end else begin
            mr = miss_inc;
            if (mr >= miss_blocks) begin hr = '0; tp = 1'b0; end
          end
          tone_present <= tp | hit_now; hit_run <= hr; miss_run <= mr;
          samples_in_block <= '0;
          input_energy_sum <= '0; output_energy_sum <= '0;
          res   <= '{detected: tp, block_done: 1'b1, batch_answer: item.batch_end};
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: sv/betd_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module betd_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 17
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic [NUM_W-1:0]      quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dreg;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  assign trial = {rem, quo[NUM_W-1]} - {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
      quo  <= num;
      rem  <= '0;
      dreg <= den;
    end else if (busy) begin
      if (!trial[DEN_W]) begin
        rem <= trial[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DEN_W-2:0], quo[NUM_W-1]};
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire
